// ===== src/hpid_pkg.sv =====
// constants, types and helpers shared by the heading pid controller
package hpid_pkg;

    localparam int FRAC_BITS  = 8;
    localparam int ERR_W      = 20;
    localparam int GAIN_W     = 24;
    localparam int LIM_W      = 19;
    localparam int DECAY_W    = 16;
    localparam int GAIN_SHIFT = 16;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = GAIN_W / DIGIT_W;
    localparam int CNT_W      = $clog2(NUM_DIGITS);
    localparam int PROD_W     = ERR_W + 1 + DIGIT_W + 2;
    localparam int LO_W       = GAIN_W - GAIN_SHIFT;
    localparam int TERM_W     = ERR_W + 1 + LO_W;
    localparam int SUM_W      = TERM_W + 2;
    localparam int IDX_W      = 3;
    localparam int CFG_W      = GAIN_W;

    localparam logic [GAIN_W-1:0]  PROP_GAIN_RST  = GAIN_W'(19661);
    localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST = GAIN_W'(655);
    localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST = GAIN_W'(13107);
    localparam logic [DECAY_W-1:0] DECAY_RST      = DECAY_W'(58982);

    // whole-unit default shifted into q format, saturated to the register
    function automatic logic [LIM_W-1:0] fit_lim(input int whole);
        longint v;
        longint lim_max;
        v       = longint'(whole) <<< FRAC_BITS;
        lim_max = (longint'(1) <<< LIM_W) - 1;
        if (v > lim_max) begin
            return {LIM_W{1'b1}};
        end
        return v[LIM_W-1:0];
    endfunction

    localparam logic [LIM_W-1:0] DEADZONE_RST  = fit_lim(5);
    localparam logic [LIM_W-1:0] INTEG_LIM_RST = fit_lim(100);
    localparam logic [LIM_W-1:0] OUT_LIM_RST   = fit_lim(35);

    typedef enum logic [IDX_W-1:0] {
        REG_PROP_GAIN  = 3'd0,
        REG_INTEG_GAIN = 3'd1,
        REG_DERIV_GAIN = 3'd2,
        REG_DEADZONE   = 3'd3,
        REG_DECAY      = 3'd4,
        REG_INTEG_LIM  = 3'd5,
        REG_OUT_LIM    = 3'd6
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECAY,
        S_UPDATE,
        S_PROP,
        S_INTEG,
        S_DERIV,
        S_FINAL,
        S_SAT
    } t_state;

endpackage

// ===== src/heading_pid_with_deadzone.sv =====
// heading pid controller with error deadzone, integral decay and anti-windup
//
// Input channel: i_in_valid / o_in_stall carry one signed Q.8 heading error a
// beat. Output channel: o_out_valid / i_out_stall carry one saturated steering
// correction per input beat, in order. Config channel: i_cfg_valid /
// o_cfg_ready write register i_cfg_index with i_cfg_data; indexes above six
// are dropped. Write config only while no beat is in flight.
// All products go through one shared multiplier that takes four bits of the
// gain per cycle. An error outside the deadzone runs the proportional,
// integral and derivative products; one inside it runs the integral decay
// product first. A new beat is taken only once the block is back in idle,
// after the last result has gone into the output register.
// The result sits in an output register; the block goes on to accept and work
// on the next beat while it waits, and holds that next result until the
// register is free, so a stalling receiver only delays the following beats.
// Synchronous reset loads the default gains and limits and clears the
// integral, the previous error and the output valid.
module heading_pid_with_deadzone (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [hpid_pkg::ERR_W-1:0]     i_heading_err,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [hpid_pkg::ERR_W-1:0]     o_steer_drive,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic        [hpid_pkg::IDX_W-1:0]     i_cfg_index,
    input  logic        [hpid_pkg::CFG_W-1:0]     i_cfg_data
);
    import hpid_pkg::*;

    logic [GAIN_W-1:0]  r_prop_gain;
    logic [GAIN_W-1:0]  r_integ_gain;
    logic [GAIN_W-1:0]  r_deriv_gain;
    logic [LIM_W-1:0]   r_deadzone;
    logic [DECAY_W-1:0] r_decay;
    logic [LIM_W-1:0]   r_integ_lim;
    logic [LIM_W-1:0]   r_out_lim;

    t_state r_state;
    t_state n_state;

    logic signed [ERR_W-1:0]  r_integ;
    logic signed [ERR_W-1:0]  r_last;
    logic signed [ERR_W-1:0]  r_err;
    logic signed [ERR_W:0]    r_ib;
    logic signed [ERR_W:0]    r_dv;
    logic signed [SUM_W-1:0]  r_sum;
    logic                     r_add;
    logic signed [TERM_W-1:0] r_term;

    logic [GAIN_W-1:0]        r_mr;
    logic signed [PROD_W-1:0] r_acc;
    logic [LO_W-1:0]          r_lo;
    logic [CNT_W-1:0]         r_cnt;

    logic                     r_out_valid;
    logic signed [ERR_W-1:0]  r_out;

    logic                     in_accept;
    logic                     out_accept;
    logic                     cfg_accept;
    logic                     mult_busy;
    logic                     mult_last;
    logic                     mult_load;
    logic                     out_free;

    logic signed [ERR_W:0]    w_err_ext;
    logic signed [ERR_W:0]    w_dz;
    logic                     w_in_dz;

    logic signed [ERR_W:0]    w_mcand;
    logic signed [DIGIT_W:0]  w_digit;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] w_psum;
    logic signed [PROD_W-1:0] n_acc;
    logic [LO_W-1:0]          n_lo;
    logic signed [TERM_W-1:0] w_term_next;
    logic [GAIN_W-1:0]        w_gain_load;

    logic signed [ERR_W:0]    w_ilim;
    logic signed [ERR_W-1:0]  w_integ_clamp;
    logic signed [SUM_W-1:0]  w_olim;
    logic signed [ERR_W-1:0]  w_out_clamp;

    assign o_cfg_ready = 1'b1;
    assign cfg_accept  = i_cfg_valid && o_cfg_ready;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_accept  = r_out_valid && !i_out_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid   = r_out_valid;
    assign o_steer_drive = r_out;

    // deadzone test, edge counts as outside
    assign w_err_ext = {i_heading_err[ERR_W-1], i_heading_err};
    assign w_dz      = {2'b00, r_deadzone};
    assign w_in_dz   = (w_err_ext > -w_dz) && (w_err_ext < w_dz);

    // one digit step of the serial multiplier
    always_comb begin
        case (r_state)
            S_DECAY: w_mcand = {r_integ[ERR_W-1], r_integ};
            S_PROP:  w_mcand = {r_err[ERR_W-1], r_err};
            S_INTEG: w_mcand = r_ib;
            default: w_mcand = r_dv;
        endcase
    end

    assign w_digit     = {1'b0, r_mr[DIGIT_W-1:0]};
    assign w_prod      = w_mcand * w_digit;
    assign w_psum      = r_acc + w_prod;
    assign n_acc       = w_psum >>> DIGIT_W;
    assign n_lo        = {w_psum[DIGIT_W-1:0], r_lo[LO_W-1:DIGIT_W]};
    assign w_term_next = {n_acc[ERR_W:0], n_lo};

    always_comb begin
        case (n_state)
            S_DECAY: w_gain_load = {{(GAIN_W-DECAY_W){1'b0}}, r_decay};
            S_PROP:  w_gain_load = r_prop_gain;
            S_INTEG: w_gain_load = r_integ_gain;
            default: w_gain_load = r_deriv_gain;
        endcase
    end

    // saturation
    assign w_ilim = {2'b00, r_integ_lim};
    always_comb begin
        if (r_ib > w_ilim) begin
            w_integ_clamp = w_ilim[ERR_W-1:0];
        end else if (r_ib < -w_ilim) begin
            w_integ_clamp = ERR_W'(-w_ilim);
        end else begin
            w_integ_clamp = r_ib[ERR_W-1:0];
        end
    end

    assign w_olim = {{(SUM_W-LIM_W){1'b0}}, r_out_lim};
    always_comb begin
        if (r_sum > w_olim) begin
            w_out_clamp = w_olim[ERR_W-1:0];
        end else if (r_sum < -w_olim) begin
            w_out_clamp = ERR_W'(-w_olim);
        end else begin
            w_out_clamp = r_sum[ERR_W-1:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = w_in_dz ? S_DECAY : S_UPDATE;
                end
            end
            S_DECAY: begin
                if (mult_last) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: n_state = S_PROP;
            S_PROP: begin
                if (mult_last) begin
                    n_state = S_INTEG;
                end
            end
            S_INTEG: begin
                if (mult_last) begin
                    n_state = S_DERIV;
                end
            end
            S_DERIV: begin
                if (mult_last) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: n_state = S_SAT;
            S_SAT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state decodes
    always_comb begin
        o_in_stall = 1'b1;
        mult_busy  = 1'b0;
        unique case (r_state)
            S_IDLE:  o_in_stall = 1'b0;
            S_DECAY, S_PROP, S_INTEG, S_DERIV: mult_busy = 1'b1;
            default: mult_busy = 1'b0;
        endcase
        mult_last = mult_busy && (r_cnt == CNT_W'(NUM_DIGITS - 1));
        mult_load = (n_state != r_state) &&
                    ((n_state == S_DECAY) || (n_state == S_PROP) ||
                     (n_state == S_INTEG) || (n_state == S_DERIV));
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain  <= PROP_GAIN_RST;
            r_integ_gain <= INTEG_GAIN_RST;
            r_deriv_gain <= DERIV_GAIN_RST;
            r_deadzone   <= DEADZONE_RST;
            r_decay      <= DECAY_RST;
            r_integ_lim  <= INTEG_LIM_RST;
            r_out_lim    <= OUT_LIM_RST;
        end else if (cfg_accept) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_PROP_GAIN:  r_prop_gain  <= i_cfg_data;
                REG_INTEG_GAIN: r_integ_gain <= i_cfg_data;
                REG_DERIV_GAIN: r_deriv_gain <= i_cfg_data;
                REG_DEADZONE:   r_deadzone   <= i_cfg_data[LIM_W-1:0];
                REG_DECAY:      r_decay      <= i_cfg_data[DECAY_W-1:0];
                REG_INTEG_LIM:  r_integ_lim  <= i_cfg_data[LIM_W-1:0];
                REG_OUT_LIM:    r_out_lim    <= i_cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_integ     <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
            r_add       <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state <= n_state;
            r_add   <= mult_last && (r_state != S_DECAY);

            if (mult_load || mult_last) begin
                r_cnt <= '0;
            end else if (mult_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end

            if (mult_last && (r_state == S_DECAY)) begin
                r_integ <= w_term_next[ERR_W-1:0];
            end else if (r_state == S_FINAL) begin
                r_integ <= w_integ_clamp;
            end

            if (r_state == S_UPDATE) begin
                r_last <= r_err;
            end

            if ((r_state == S_SAT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (out_accept) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_err <= w_in_dz ? '0 : i_heading_err;
        end

        if (r_state == S_UPDATE) begin
            r_ib  <= {r_integ[ERR_W-1], r_integ} + {r_err[ERR_W-1], r_err};
            r_dv  <= {r_err[ERR_W-1], r_err} - {r_last[ERR_W-1], r_last};
            r_sum <= '0;
        end else if (r_add) begin
            r_sum <= r_sum + {{(SUM_W-TERM_W){r_term[TERM_W-1]}}, r_term};
        end

        if (mult_last) begin
            r_term <= w_term_next;
        end

        if (mult_load) begin
            r_mr  <= w_gain_load;
            r_acc <= '0;
        end else if (mult_busy) begin
            r_mr  <= r_mr >> DIGIT_W;
            r_acc <= n_acc;
            r_lo  <= n_lo;
        end

        if ((r_state == S_SAT) && out_free) begin
            r_out <= w_out_clamp;
        end
    end

    // checks
    a_stall_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_in_stall)
        else $error("input beat taken while an item is in flight");

    a_digit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(NUM_DIGITS - 1))
        else $error("digit counter out of range");

    a_integ_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINAL) |=>
            ($signed({r_integ[ERR_W-1], r_integ}) <= $past(w_ilim)) &&
            ($signed({r_integ[ERR_W-1], r_integ}) >= -$past(w_ilim)))
        else $error("integral outside its limit after clamping");

    a_out_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SAT) && out_free) |=>
            ($signed({{(SUM_W-ERR_W){r_out[ERR_W-1]}}, r_out}) <= $past(w_olim)) &&
            ($signed({{(SUM_W-ERR_W){r_out[ERR_W-1]}}, r_out}) >= -$past(w_olim)))
        else $error("result outside output limit");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SAT) && r_out_valid && i_out_stall) |=> (r_state == S_SAT))
        else $error("sequencer left saturation while result still pending");

endmodule
